### rtl/utv_pkg.sv
`default_nettype none

package utv_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 17;
    localparam int OWED_W  = 2;
    localparam int RULE_W  = 3;

    localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = 16'd255;
    localparam logic [COUNT_W-1:0] COUNT_SAT      = 17'h1FFFF;

    // range rule for the first continuation byte after certain leads
    localparam logic [RULE_W-1:0] RULE_NONE   = 3'd0;
    localparam logic [RULE_W-1:0] RULE_GE_A0  = 3'd1;
    localparam logic [RULE_W-1:0] RULE_LT_A0  = 3'd2;
    localparam logic [RULE_W-1:0] RULE_GE_90  = 3'd3;
    localparam logic [RULE_W-1:0] RULE_LT_90  = 3'd4;

    localparam logic [BYTE_W-1:0] ASCII_TOP   = 8'h80;
    localparam logic [BYTE_W-1:0] CTRL_TOP    = 8'h20;
    localparam logic [BYTE_W-1:0] DEL_CHAR    = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_SURR  = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
    localparam logic [BYTE_W-1:0] BOUND_A0    = 8'hA0;
    localparam logic [BYTE_W-1:0] BOUND_90    = 8'h90;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_beat;

    function automatic logic rule_ok(input logic [RULE_W-1:0] rule,
                                     input logic [BYTE_W-1:0] b);
        logic ok;
        begin
            unique case (rule)
                RULE_GE_A0: ok = (b >= BOUND_A0);
                RULE_LT_A0: ok = (b < BOUND_A0);
                RULE_GE_90: ok = (b >= BOUND_90);
                RULE_LT_90: ok = (b < BOUND_90);
                default:    ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/utv_in_stage.sv
`default_nettype none

module utv_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_last,
    output logic               o_stall,
    input  wire logic          i_take,
    output logic               o_beat_valid,
    output utv_pkg::t_beat     o_beat
);
    import utv_pkg::*;

    logic  r_valid;
    t_beat r_beat;
    logic  load;

    // register frees up when its beat moves on this edge
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat.data <= i_data;
            r_beat.last <= i_last;
        end
    end

    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

endmodule

`default_nettype wire

### rtl/utv_scan.sv
`default_nettype none

module utv_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_beat_valid,
    input  wire utv_pkg::t_beat i_beat,
    input  wire logic [15:0]   i_max_length,
    input  wire logic          i_out_free,
    output logic               o_take,
    output logic               o_fire,
    output logic               o_verdict
);
    import utv_pkg::*;

    logic [OWED_W-1:0]  r_owed, n_owed;
    logic [RULE_W-1:0]  r_rule, n_rule;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_err, n_err;
    logic [BYTE_W-1:0]  b;
    logic               bad;

    assign b = i_beat.data;

    always_comb begin
        n_owed = r_owed;
        n_rule = r_rule;
        bad    = 1'b0;
        if (r_owed != '0) begin
            // a non-continuation here is still consumed as the owed byte
            bad    = ((b & CONT_MASK) != CONT_TAG) || !rule_ok(r_rule, b);
            n_rule = RULE_NONE;
            n_owed = r_owed - OWED_W'(1);
        end else if (b < ASCII_TOP) begin
            bad = (b < CTRL_TOP) || (b == DEL_CHAR);
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            n_owed = OWED_W'(1);
            n_rule = RULE_NONE;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            n_owed = OWED_W'(2);
            n_rule = (b == LEAD3_LO) ? RULE_GE_A0 :
                     (b == LEAD3_SURR) ? RULE_LT_A0 : RULE_NONE;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            n_owed = OWED_W'(3);
            n_rule = (b == LEAD4_LO) ? RULE_GE_90 :
                     (b == LEAD4_HI) ? RULE_LT_90 : RULE_NONE;
        end else begin
            bad = 1'b1;
        end
        n_err   = r_err | bad;
        n_count = (r_count == COUNT_SAT) ? r_count : r_count + COUNT_W'(1);
    end

    // a last beat waits only if the result register is still occupied
    assign o_take    = i_beat_valid && (!i_beat.last || i_out_free);
    assign o_fire    = o_take && i_beat.last;
    assign o_verdict = !n_err && (n_owed == '0) && (n_count <= {1'b0, i_max_length});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed  <= '0;
            r_rule  <= RULE_NONE;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (o_take) begin
            if (i_beat.last) begin
                r_owed  <= '0;
                r_rule  <= RULE_NONE;
                r_count <= '0;
                r_err   <= 1'b0;
            end else begin
                r_owed  <= n_owed;
                r_rule  <= n_rule;
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/utf8_text_validator_top.sv
// a string's last byte is registered at the input, then its verdict is registered on o_valid
// throughput: one byte per cycle; the input stalls only while a verdict waits
//   in the result register and a last byte is behind it
// reset (i_rst_n low at a clock edge): per-string state and valid flags clear,
//   max_length returns to 255
`default_nettype none

module utf8_text_validator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_string_valid,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import utv_pkg::*;

    logic [LEN_W-1:0] r_max_length;
    logic             r_out_valid;
    logic             r_out_data;
    logic             beat_valid;
    t_beat            beat;
    logic             take;
    logic             fire;
    logic             verdict;
    logic             out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_length <= i_cfg_data;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    utv_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_byte_value),
        .i_last      (i_last_byte),
        .o_stall     (o_stall),
        .i_take      (take),
        .o_beat_valid(beat_valid),
        .o_beat      (beat)
    );

    utv_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat_valid(beat_valid),
        .i_beat      (beat),
        .i_max_length(r_max_length),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_fire      (fire),
        .o_verdict   (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= verdict;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_string_valid = r_out_data;

endmodule

`default_nettype wire

### rtl/utv_port_checker.sv
`default_nettype none

module utv_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_last_byte,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_string_valid
);

    // held verdict beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("verdict beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_string_valid))
        else $error("verdict changed while stalled");

    // input backpressure only comes from a blocked result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with result side free");

    // a fresh verdict comes from an accepted last byte, via the input and result registers
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_last_byte, 2))
        else $error("verdict without a last byte");

endmodule

bind utf8_text_validator_top utv_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_last_byte   (i_last_byte),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_string_valid(o_string_valid)
);

`default_nettype wire

### dv/tb_utf8_text_validator_top.sv
module tb_utf8_text_validator_top;
    import utv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 190;
    localparam int PHASES         = 7;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_byte_value   = '0;
    logic        i_last_byte    = 1'b0;
    logic        i_stall        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_string_valid;
    logic        o_cfg_ready;

    utf8_text_validator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_string_valid (o_string_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [LEN_W-1:0]   len_limit = MAX_LENGTH_RST;
    logic [OWED_W-1:0]  owed      = '0;
    logic [RULE_W-1:0]  cont_rule = RULE_NONE;
    logic [COUNT_W-1:0] run_len   = '0;
    logic               bad       = 1'b0;

    t_beat       byte_q[$];
    logic        verdict_q[$];
    logic [7:0]  text_buf[$];

    int mismatches     = 0;
    int strings_seen   = 0;
    int good_strings   = 0;
    int bytes_queued   = 0;
    int phase_bytes    = 0;
    int settings_used  = 1;
    int send_gap       = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    bit idle_on        = 1'b1;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // advance the string checker by one byte, queue a verdict on the last one
    task automatic utf8_absorb(input logic [7:0] b, input logic fin);
        logic ok;
        logic verdict;
        if (run_len != COUNT_SAT)
            run_len++;
        if (owed != 0) begin
            ok = ((b & CONT_MASK) == CONT_TAG);
            case (cont_rule)
                RULE_GE_A0: if (b < BOUND_A0) ok = 1'b0;
                RULE_LT_A0: if (b >= BOUND_A0) ok = 1'b0;
                RULE_GE_90: if (b < BOUND_90) ok = 1'b0;
                RULE_LT_90: if (b >= BOUND_90) ok = 1'b0;
                default: ;
            endcase
            if (!ok)
                bad = 1'b1;
            // a bad byte still pays off one owed continuation
            cont_rule = RULE_NONE;
            owed = owed - 1'b1;
        end else if (b < ASCII_TOP) begin
            if (b < CTRL_TOP || b == DEL_CHAR)
                bad = 1'b1;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            owed = 2'd1;
            cont_rule = RULE_NONE;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            owed = 2'd2;
            cont_rule = (b == LEAD3_LO) ? RULE_GE_A0 :
                        (b == LEAD3_SURR) ? RULE_LT_A0 : RULE_NONE;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            owed = 2'd3;
            cont_rule = (b == LEAD4_LO) ? RULE_GE_90 :
                        (b == LEAD4_HI) ? RULE_LT_90 : RULE_NONE;
        end else begin
            bad = 1'b1;
        end
        if (fin) begin
            verdict = !bad && owed == 0 && run_len <= {1'b0, len_limit};
            verdict_q = {verdict_q, verdict};
            strings_seen++;
            if (verdict)
                good_strings++;
            owed = '0;
            cont_rule = RULE_NONE;
            run_len = '0;
            bad = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall)
                utf8_absorb(i_byte_value, i_last_byte);
            if (i_valid && o_stall) begin
                // stalled beat stays put
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                t_beat nb;
                nb = byte_q.pop_front();
                i_valid      <= 1'b1;
                i_byte_value <= nb.data;
                i_last_byte  <= nb.last;
                send_gap = idle_on ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver and verdict check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("verdict with no string pending");
                end else begin
                    logic want;
                    want = verdict_q.pop_front();
                    if (o_string_valid !== want)
                        flag_mismatch($sformatf("string_valid %b, predicted %b",
                                                o_string_valid, want));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic flush_text();
        t_beat nb;
        for (int i = 0; i < text_buf.size(); i++) begin
            nb.data = text_buf[i];
            nb.last = (i == text_buf.size() - 1);
            byte_q = {byte_q, nb};
        end
        bytes_queued += text_buf.size();
        phase_bytes  += text_buf.size();
        text_buf.delete();
    endtask

    task automatic add_text_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    function automatic logic [7:0] cont_byte(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    task automatic add_good_char();
        int k;
        logic [7:0] lead;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            add_text_byte(8'($urandom_range(CTRL_TOP, DEL_CHAR - 1)));
        end else if (k < 6) begin
            add_text_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            add_text_byte(cont_byte(CONT_TAG, 8'hBF));
        end else if (k < 8) begin
            lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            add_text_byte(lead);
            if (lead == LEAD3_LO)
                add_text_byte(cont_byte(BOUND_A0, 8'hBF));
            else if (lead == LEAD3_SURR)
                add_text_byte(cont_byte(CONT_TAG, BOUND_A0 - 1));
            else
                add_text_byte(cont_byte(CONT_TAG, 8'hBF));
            add_text_byte(cont_byte(CONT_TAG, 8'hBF));
        end else begin
            lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
            add_text_byte(lead);
            if (lead == LEAD4_LO)
                add_text_byte(cont_byte(BOUND_90, 8'hBF));
            else if (lead == LEAD4_HI)
                add_text_byte(cont_byte(CONT_TAG, BOUND_90 - 1));
            else
                add_text_byte(cont_byte(CONT_TAG, 8'hBF));
            add_text_byte(cont_byte(CONT_TAG, 8'hBF));
            add_text_byte(cont_byte(CONT_TAG, 8'hBF));
        end
    endtask

    // mostly well-formed text, the rest noise, a corrupted byte or a cut-off tail
    task automatic queue_random_text();
        int kind;
        int nchars;
        kind = $urandom_range(0, 99);
        nchars = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        if (kind < 12) begin
            repeat ($urandom_range(1, 6))
                add_text_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat (nchars)
                add_good_char();
            if (kind < 20)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            else if (kind < 27)
                add_text_byte(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
        end
        flush_text();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_q.size() != 0 || i_valid || verdict_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        len_limit = v;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [15:0] limits[PHASES];
        limits = '{16'd0, 16'd1, 16'd3, 16'd8, 16'd16, 16'hFFFF,
                   16'($urandom_range(2, 24))};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short directed strings under the reset length limit
        text_buf = '{8'h00};                    flush_text(); // control char
        text_buf = '{8'h7F};                    flush_text(); // DEL
        text_buf = '{8'h20, 8'h7E};             flush_text(); // printable edges
        text_buf = '{8'hFF};                    flush_text(); // never a lead
        text_buf = '{8'h80};                    flush_text(); // stray continuation
        text_buf = '{8'hE0, 8'h9F, 8'h80};      flush_text(); // overlong three-byte
        text_buf = '{8'hED, 8'hA0, 8'h80};      flush_text(); // surrogate
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; flush_text(); // above U+10FFFF
        text_buf = '{8'hF0, 8'h90, 8'h80, 8'h80}; flush_text(); // lowest four-byte
        text_buf = '{8'hC2, 8'h41};             flush_text(); // missing continuation
        text_buf = '{8'hE1, 8'h80};             flush_text(); // cut short at the end
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_max_length(limits[ph]);
            idle_on = (ph % 3) != 1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                queue_random_text();
            wait_drained();
        end

        $display("checked %0d strings (%0d bytes), %0d of them well-formed and in length",
                 strings_seen, bytes_queued, good_strings);
        $display("max_length took %0d settings, 0 and 0xFFFF among them", settings_used);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
